/* rtl/core/gcc_pkg.sv */
// Shared types and constants for the greedy graph colouring core.
// No dependencies; used by gcc_lane, gcc_merge and greedy_graph_coloring_core.
package gcc_pkg;

    localparam int COLOR_W    = 5;
    localparam int COUNT_W    = 6;
    localparam int MASK_W     = 32;
    localparam int NUM_COLORS = 32;
    localparam int CFG_W      = 6;
    localparam int OUT_DATA_W = 16;

    localparam logic [COLOR_W-1:0] COLOR_MAX   = 5'd31;
    localparam logic [CFG_W-1:0]   COUNT_RESET = 6'd32;

    typedef logic [COLOR_W-1:0]    color_t;
    typedef logic [NUM_COLORS-1:0] color_set_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_PICK = 2'b10
    } state_t;

endpackage

/* rtl/core/gcc_lane.sv */
// One neighbour lane: turns a neighbour's stored colour into a one-hot mark.
// Depends on gcc_pkg.
module gcc_lane (
    input  logic               en,
    input  gcc_pkg::color_t    color,
    output gcc_pkg::color_set_t mark
);

    always_comb begin
        mark = '0;
        if (en) begin
            mark[color] = 1'b1;
        end
    end

endmodule

/* rtl/core/gcc_merge.sv */
// Merging stage: ORs the lane marks into a registered used-colour set and
// picks the lowest free colour. Depends on gcc_pkg.
module gcc_merge #(
    parameter int NUM_LANES = 32
) (
    input  logic                                aclk,
    input  logic                                load,
    input  gcc_pkg::color_set_t [NUM_LANES-1:0] marks,
    output gcc_pkg::color_t                     pick
);

    gcc_pkg::color_set_t used_reg;
    gcc_pkg::color_set_t used_next;
    gcc_pkg::color_set_t free_set;
    gcc_pkg::color_set_t lowest;

    always_comb begin
        used_next = '0;
        for (int j = 0; j < NUM_LANES; j++) begin
            used_next = used_next | marks[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            used_reg <= used_next;
        end
    end

    assign free_set = ~used_reg;
    assign lowest   = free_set & (~free_set + gcc_pkg::color_set_t'(1));

    always_comb begin
        pick = '0;
        if (free_set == '0) begin
            pick = gcc_pkg::COLOR_MAX;
        end else begin
            for (int i = 0; i < gcc_pkg::NUM_COLORS; i++) begin
                if (lowest[i]) begin
                    pick = pick | gcc_pkg::color_t'(i);
                end
            end
        end
    end

endmodule

/* rtl/core/greedy_graph_coloring_core.sv */
// First-fit greedy graph colouring core: one adjacency row in, one colour out.
// Depends on gcc_pkg, gcc_lane and gcc_merge.
//
// Each item on the s_ channel is the neighbour mask of the next vertex in
// index order; the core answers with the vertex's colour, the running colour
// count and tlast on the final vertex set by the cfg register (0 counts as 1,
// values above MAX_VERTICES as MAX_VERTICES). In the accept cycle one lane per
// earlier vertex marks that neighbour's colour and the merging stage registers
// the used-colour set; the pick state takes the lowest free colour and, once
// the output register is free, updates the colour table. A finished result
// sits in the output register while the next item is taken. Only the first
// 32 vertices can be named as neighbours; with all 32 colours taken the colour saturates at 31.
module greedy_graph_coloring_core #(
    parameter int MAX_VERTICES = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [gcc_pkg::MASK_W-1:0]        s_tdata,   // [31:0] neighbor_mask
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [gcc_pkg::OUT_DATA_W-1:0]    m_tdata,   // [4:0] vertex_color, [10:5] color_count
    output logic                              m_tlast,   // last
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gcc_pkg::CFG_W-1:0]         cfg_data   // [5:0] vertex_count
);

    localparam int NUM_LANES = (MAX_VERTICES < gcc_pkg::MASK_W) ? MAX_VERTICES
                                                                : gcc_pkg::MASK_W;
    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int CMP_W = (IDX_W + 1 > gcc_pkg::CFG_W) ? IDX_W + 1 : gcc_pkg::CFG_W;

    gcc_pkg::state_t                      state_reg, state_next;
    logic [IDX_W-1:0]                     vertex_index_reg, vertex_index_next;
    gcc_pkg::color_t                      max_color_reg, max_color_next;
    logic [gcc_pkg::CFG_W-1:0]            vertex_count_reg;
    gcc_pkg::color_t                      colors_reg [NUM_LANES];
    logic                                 m_valid_reg;
    gcc_pkg::color_t                      out_color_reg;
    logic [gcc_pkg::COUNT_W-1:0]          out_count_reg;
    logic                                 out_last_reg;

    gcc_pkg::color_set_t [NUM_LANES-1:0]  marks;
    gcc_pkg::color_t                      pick_color;
    gcc_pkg::color_t                      base_max;
    logic [CMP_W-1:0]                     count_ext;
    logic [CMP_W-1:0]                     eff_count;
    logic                                 is_last;
    logic                                 s_accept;
    logic                                 complete;

    assign s_tready  = (state_reg == gcc_pkg::ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign complete  = (state_reg == gcc_pkg::ST_PICK) && (!m_valid_reg || m_tready);
    assign cfg_ready = 1'b1;

    for (genvar j = 0; j < NUM_LANES; j++) begin : g_lane
        gcc_lane u_lane (
            .en    (s_tdata[j] && (IDX_W'(j) < vertex_index_reg)),
            .color (colors_reg[j]),
            .mark  (marks[j])
        );
    end

    gcc_merge #(
        .NUM_LANES (NUM_LANES)
    ) u_merge (
        .aclk  (aclk),
        .load  (s_accept),
        .marks (marks),
        .pick  (pick_color)
    );

    always_comb begin
        count_ext = CMP_W'(vertex_count_reg);
        if (count_ext == '0) begin
            eff_count = CMP_W'(1);
        end else if (count_ext > CMP_W'(MAX_VERTICES)) begin
            eff_count = CMP_W'(MAX_VERTICES);
        end else begin
            eff_count = count_ext;
        end
        is_last  = (CMP_W'(vertex_index_reg) + CMP_W'(1)) >= eff_count;
        base_max = (vertex_index_reg == '0) ? '0 : max_color_reg;
        max_color_next = (pick_color > base_max) ? pick_color : base_max;
        vertex_index_next = is_last ? '0 : vertex_index_reg + IDX_W'(1);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gcc_pkg::ST_IDLE: begin
                if (s_accept) begin
                    state_next = gcc_pkg::ST_PICK;
                end
            end
            gcc_pkg::ST_PICK: begin
                if (complete) begin
                    state_next = gcc_pkg::ST_IDLE;
                end
            end
            default: state_next = gcc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= gcc_pkg::ST_IDLE;
            vertex_index_reg <= '0;
            max_color_reg    <= '0;
            vertex_count_reg <= gcc_pkg::COUNT_RESET;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                vertex_count_reg <= cfg_data;
            end
            if (complete) begin
                vertex_index_reg <= vertex_index_next;
                max_color_reg    <= max_color_next;
                m_valid_reg      <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (complete) begin
            out_color_reg <= pick_color;
            out_count_reg <= gcc_pkg::COUNT_W'(max_color_next) + gcc_pkg::COUNT_W'(1);
            out_last_reg  <= is_last;
        end
    end

    for (genvar j = 0; j < NUM_LANES; j++) begin : g_store
        always_ff @(posedge aclk) begin
            if (complete && (vertex_index_reg == IDX_W'(j))) begin
                colors_reg[j] <= pick_color;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(gcc_pkg::OUT_DATA_W - gcc_pkg::COUNT_W - gcc_pkg::COLOR_W){1'b0}},
                       out_count_reg, out_color_reg};

    a_accept_to_pick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == gcc_pkg::ST_PICK))
        else $error("accepted item did not enter pick stage");

    a_last_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (complete && is_last) |=> (vertex_index_reg == '0))
        else $error("vertex index not restarted after last vertex");

    a_first_vertex_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (complete && (vertex_index_reg == '0)) |-> (pick_color == '0))
        else $error("first vertex not given colour zero");

    a_count_above_color: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (out_count_reg > gcc_pkg::COUNT_W'(out_color_reg)))
        else $error("colour count not above vertex colour");

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for greedy_graph_coloring_core: first-fit colouring of adjacency rows.
// Depends on gcc_pkg and the core. Results are predicted per accepted row and checked in order.
// Covers the special cases, a full clique, back-pressure and random graphs at several sizes.
`timescale 1ns / 100ps

module tb_top;

    localparam int MAX_VERTICES = 32;
    localparam int STALL_LIMIT  = 2000;

    typedef struct packed {
        gcc_pkg::color_t             color;
        logic [gcc_pkg::COUNT_W-1:0] count;
        logic                        last;
    } vertex_result_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [gcc_pkg::MASK_W-1:0]     s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [gcc_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           m_tlast;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [gcc_pkg::CFG_W-1:0]      cfg_data;

    // predictor state
    gcc_pkg::color_t           colour_table [MAX_VERTICES];
    int                        vtx_index = 0;
    gcc_pkg::color_t           max_colour = '0;
    logic [gcc_pkg::CFG_W-1:0] vertex_count_cfg = gcc_pkg::COUNT_RESET;
    vertex_result_t            expected_colours [$];

    int mismatches   = 0;
    int src_gap_max  = 8;
    int sink_gap_max = 8;
    int sink_hold    = 0;

    greedy_graph_coloring_core #(
        .MAX_VERTICES(MAX_VERTICES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    function automatic vertex_result_t colour_vertex(input logic [gcc_pkg::MASK_W-1:0] mask);
        gcc_pkg::color_set_t taken;
        vertex_result_t      r;
        int                  eff;
        taken = '0;
        if (vtx_index == 0)
            max_colour = '0;
        // only already-coloured vertices of this graph count
        for (int j = 0; j < MAX_VERTICES; j++)
            if (j < vtx_index && mask[j])
                taken[colour_table[j]] = 1'b1;
        r.color = gcc_pkg::COLOR_MAX;
        for (int j = gcc_pkg::NUM_COLORS - 1; j >= 0; j--)
            if (!taken[j])
                r.color = gcc_pkg::color_t'(j);
        colour_table[vtx_index] = r.color;
        if (r.color > max_colour)
            max_colour = r.color;
        r.count = {1'b0, max_colour} + 6'd1;
        if (vertex_count_cfg == 0)
            eff = 1;
        else if (vertex_count_cfg > MAX_VERTICES)
            eff = MAX_VERTICES;
        else
            eff = int'(vertex_count_cfg);
        r.last = (vtx_index + 1 >= eff);
        vtx_index = r.last ? 0 : vtx_index + 1;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    task automatic check_result();
        vertex_result_t want;
        if (expected_colours.size() == 0) begin
            report_mismatch("unexpected result item", int'(m_tdata), 0);
        end else begin
            want = expected_colours.pop_front();
            if (m_tdata[4:0] !== want.color)
                report_mismatch("vertex_color", int'(m_tdata[4:0]), int'(want.color));
            if (m_tdata[10:5] !== want.count)
                report_mismatch("color_count", int'(m_tdata[10:5]), int'(want.count));
            if (m_tlast !== want.last)
                report_mismatch("last", int'(m_tlast), int'(want.last));
            if (m_tdata[15:11] !== '0)
                report_mismatch("tdata padding", int'(m_tdata[15:11]), 0);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                vertex_count_cfg = cfg_data;
            if (s_tvalid && s_tready)
                expected_colours.push_back(colour_vertex(s_tdata));
            if (m_tvalid && m_tready)
                check_result();
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : result_sink
        int wait_cycles;
        m_tready = 1'b0;
        forever begin
            if (sink_hold > 0) begin
                wait_cycles = sink_hold;
                sink_hold = 0;
            end else begin
                wait_cycles = $urandom_range(0, sink_gap_max);
            end
            if (wait_cycles > 0) begin
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (wait_cycles - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    task automatic send_row(input logic [gcc_pkg::MASK_W-1:0] mask);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= mask;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_colours.size() != 0) @(negedge aclk);
    endtask

    task automatic write_vertex_count(input logic [gcc_pkg::CFG_W-1:0] value);
        drain();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [gcc_pkg::MASK_W-1:0] random_row();
        logic [gcc_pkg::MASK_W-1:0] row;
        case ($urandom_range(0, 9))
            0: row = '0;
            1: row = '1;
            2, 3, 4: row = $urandom;
            5, 6: row = $urandom & $urandom;
            7, 8: row = $urandom | $urandom;
            default: row = 32'd1 << $urandom_range(0, gcc_pkg::MASK_W - 1);
        endcase
        return row;
    endfunction

    // reset vertex count; vertex zero ignores its mask, self and later bits ignored
    task automatic test_first_fit();
        send_row('1);
        send_row(32'h0000_0001);
        send_row(32'hFFFF_FFFC);
        send_row(32'h0000_0007);
        send_row(32'h0000_000A);
    endtask

    // shrinking the count mid-graph ends the graph at once; 0 acts as 1
    task automatic test_count_change();
        write_vertex_count(6'd3);
        send_row('0);
        send_row('1);
        send_row(32'h0000_0001);
        write_vertex_count(6'd0);
        send_row('1);
        send_row(32'h5555_5555);
    endtask

    // every vertex adjacent to all earlier ones: colours 0..31, count saturates the table
    task automatic test_full_clique();
        write_vertex_count(6'd63);
        repeat (MAX_VERTICES) send_row('1);
    endtask

    task automatic test_backpressure();
        write_vertex_count(6'd32);
        src_gap_max = 0;
        sink_hold = 300;
        repeat (40) send_row(random_row());
        src_gap_max = 8;
    endtask

    task automatic test_sender_pause();
        repeat (3) begin
            repeat (10) send_row(random_row());
            drain();
        end
    endtask

    task automatic test_random_graphs();
        logic [gcc_pkg::CFG_W-1:0] sizes [8] = '{6'd1, 6'd2, 6'd32, 6'd0,
                                                 6'd63, 6'd33, 6'd7, 6'd31};
        for (int p = 0; p < 12; p++) begin
            write_vertex_count(p < 8 ? sizes[p]
                                     : gcc_pkg::CFG_W'($urandom_range(0, 63)));
            src_gap_max  = (p % 3 == 0) ? 0 : 8;
            sink_gap_max = (p % 4 == 1) ? 0 : 8;
            repeat ($urandom_range(80, 120)) send_row(random_row());
        end
        src_gap_max  = 8;
        sink_gap_max = 8;
    endtask

    initial begin : stimulus
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_first_fit();
        test_count_change();
        test_full_clique();
        test_backpressure();
        test_sender_pause();
        test_random_graphs();

        drain();
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
